FILE: rtl/atilt_pkg.sv
`default_nettype none
package atilt_pkg;

    // configuration of the cordic, clamped to the range of the angle table
    localparam int ITERATIONS          = 16;
    localparam int ANGLE_FRACTION_BITS = 16;
    localparam int TABLE_LEN           = 24;
    localparam int TABLE_FRAC          = 24;

    localparam int N_STAGES = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
    localparam int FRAC     = (ANGLE_FRACTION_BITS > TABLE_FRAC) ? TABLE_FRAC
                                                                 : ANGLE_FRACTION_BITS;

    // fixed field widths
    localparam int WORD_W    = 16;
    localparam int SCALED_W  = 14;
    localparam int DEG_W     = 9;
    localparam int VEC_SHIFT = 16;
    localparam int VEC_W     = 34;
    localparam int ACC_W     = FRAC + 11;
    localparam int MAG_W     = ACC_W - FRAC;

    // input register, cordic stages, output register
    localparam int LATENCY = N_STAGES + 2;

    localparam logic signed [DEG_W-1:0] DEG_0    = 9'sd0;
    localparam logic signed [DEG_W-1:0] DEG_45   = 9'sd45;
    localparam logic signed [DEG_W-1:0] DEG_90   = 9'sd90;
    localparam logic signed [DEG_W-1:0] DEG_135  = 9'sd135;
    localparam logic signed [DEG_W-1:0] DEG_180  = 9'sd180;
    localparam logic signed [DEG_W-1:0] DEG_N90  = -9'sd90;
    localparam logic signed [DEG_W-1:0] DEG_N180 = -9'sd180;

    localparam logic [MAG_W-1:0] MAG_180 = MAG_W'(180);

    localparam logic signed [ACC_W-1:0] ACC_POS_180 = ACC_W'(longint'(180) <<< FRAC);
    localparam logic signed [ACC_W-1:0] ACC_NEG_180 = -ACC_POS_180;

    // atan(2^-i) in degrees with 24 fraction bits, rounded to nearest
    localparam longint ANGLE_TABLE [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938,
        60000934,  30029717,  15018523,  7509720,
        3754917,   1877466,   938734,    469367,
        234684,    117342,    58671,     29335,
        14668,     7334,      3667,      1833,
        917,       458,       229,       115
    };

    localparam int     ANG_SHIFT = TABLE_FRAC - FRAC;
    localparam longint ANG_HALF  = (ANG_SHIFT == 0) ? 0 : (longint'(1) <<< (ANG_SHIFT - 1));

    // stage angle reduced to FRAC fraction bits, round half up
    function automatic logic [63:0] stage_angle(input int idx);
        longint t;
        t = ANGLE_TABLE[idx % TABLE_LEN];
        return 64'((t + ANG_HALF) >>> ANG_SHIFT);
    endfunction

    typedef struct packed {
        logic                       special;
        logic signed [DEG_W-1:0]    fixed_deg;
        logic signed [VEC_W-1:0]    vx;
        logic signed [VEC_W-1:0]    vy;
        logic signed [ACC_W-1:0]    acc;
    } t_stage;

endpackage
`default_nettype wire

FILE: rtl/atilt_prep.sv
`default_nettype none
module atilt_prep (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    input  wire logic signed [atilt_pkg::WORD_W-1:0]     i_y_word,
    input  wire logic signed [atilt_pkg::WORD_W-1:0]     i_z_word,
    output logic                                         o_valid,
    output atilt_pkg::t_stage                            o_stage
);
    import atilt_pkg::*;

    logic signed [WORD_W-1:0]   y_adj, z_adj;
    logic signed [SCALED_W-1:0] y_s, z_s;
    logic signed [SCALED_W:0]   y_e, z_e, ay, az, z_sel, y_sel;
    logic                       y_zero, z_zero, z_neg, y_pos;
    logic signed [DEG_W-1:0]    diag_deg;
    t_stage                     n_stage;
    t_stage                     r_stage;
    logic                       r_valid;

    // truncating divide by four: bias negatives by three before the shift
    assign y_adj = i_y_word + {{(WORD_W-2){1'b0}}, {2{i_y_word[WORD_W-1]}}};
    assign z_adj = i_z_word + {{(WORD_W-2){1'b0}}, {2{i_z_word[WORD_W-1]}}};
    assign y_s   = y_adj[WORD_W-1:2];
    assign z_s   = z_adj[WORD_W-1:2];

    assign y_e   = {y_s[SCALED_W-1], y_s};
    assign z_e   = {z_s[SCALED_W-1], z_s};
    assign ay    = y_s[SCALED_W-1] ? -y_e : y_e;
    assign az    = z_s[SCALED_W-1] ? -z_e : z_e;

    assign y_zero = (y_s == '0);
    assign z_zero = (z_s == '0);
    assign z_neg  = z_s[SCALED_W-1];
    assign y_pos  = !y_s[SCALED_W-1] && !y_zero;

    // left half-plane: rotate by 180 degrees before the cordic
    assign z_sel = z_neg ? -z_e : z_e;
    assign y_sel = z_neg ? -y_e : y_e;

    always_comb begin
        diag_deg = z_neg ? DEG_135 : DEG_45;
        if (y_s[SCALED_W-1]) begin
            diag_deg = -diag_deg;
        end

        n_stage.special   = 1'b1;
        n_stage.fixed_deg = DEG_0;
        if (y_zero) begin
            n_stage.fixed_deg = z_neg ? DEG_180 : DEG_0;
        end else if (z_zero) begin
            n_stage.fixed_deg = y_pos ? DEG_90 : DEG_N90;
        end else if (ay == az) begin
            n_stage.fixed_deg = diag_deg;
        end else begin
            n_stage.special = 1'b0;
        end

        n_stage.vx  = {{(VEC_W-SCALED_W-1-VEC_SHIFT){z_sel[SCALED_W]}}, z_sel,
                       {VEC_SHIFT{1'b0}}};
        n_stage.vy  = {{(VEC_W-SCALED_W-1-VEC_SHIFT){y_sel[SCALED_W]}}, y_sel,
                       {VEC_SHIFT{1'b0}}};
        n_stage.acc = '0;
        if (z_neg) begin
            n_stage.acc = y_pos ? ACC_POS_180 : ACC_NEG_180;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

FILE: rtl/atilt_cordic.sv
`default_nettype none
module atilt_cordic (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire atilt_pkg::t_stage   i_stage,
    output logic                     o_valid,
    output atilt_pkg::t_stage        o_stage
);
    import atilt_pkg::*;

    t_stage               r_pipe [N_STAGES];
    logic [N_STAGES-1:0]  r_valid;

    for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
        localparam logic [63:0]             ANG64 = stage_angle(g);
        localparam logic signed [ACC_W-1:0] ANG   = $signed(ANG64[ACC_W-1:0]);

        t_stage s_in;
        t_stage n_out;
        logic   v_in;
        logic signed [VEC_W-1:0] dx, dy;

        if (g == 0) begin : g_first
            assign s_in = i_stage;
            assign v_in = i_valid;
        end else begin : g_next
            assign s_in = r_pipe[g-1];
            assign v_in = r_valid[g-1];
        end

        // floor shifts of the other component
        assign dx = s_in.vy >>> g;
        assign dy = s_in.vx >>> g;

        always_comb begin
            n_out = s_in;
            if (s_in.vy > 0) begin
                n_out.vx  = s_in.vx + dx;
                n_out.vy  = s_in.vy - dy;
                n_out.acc = s_in.acc + ANG;
            end else begin
                n_out.vx  = s_in.vx - dx;
                n_out.vy  = s_in.vy + dy;
                n_out.acc = s_in.acc - ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= v_in;
            end
            r_pipe[g] <= n_out;
        end
    end

    assign o_valid = r_valid[N_STAGES-1];
    assign o_stage = r_pipe[N_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/atilt_post.sv
`default_nettype none
module atilt_post (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire atilt_pkg::t_stage                   i_stage,
    output logic                                     o_strobe,
    output logic signed [atilt_pkg::DEG_W-1:0]       o_roll_degrees
);
    import atilt_pkg::*;

    logic signed [ACC_W-1:0] acc_neg, acc_mag;
    logic [MAG_W-1:0]        whole;
    logic                    neg;
    logic signed [DEG_W-1:0] n_roll;
    logic signed [DEG_W-1:0] r_roll;
    logic                    r_strobe;

    // truncate toward zero on the magnitude, then saturate to a half turn
    assign neg     = i_stage.acc[ACC_W-1];
    assign acc_neg = -i_stage.acc;
    assign acc_mag = neg ? acc_neg : i_stage.acc;
    assign whole   = acc_mag[ACC_W-1:FRAC];

    always_comb begin
        if (i_stage.special) begin
            n_roll = i_stage.fixed_deg;
        end else if (whole > MAG_180) begin
            n_roll = neg ? DEG_N180 : DEG_180;
        end else if (neg) begin
            n_roll = -$signed(whole[DEG_W-1:0]);
        end else begin
            n_roll = $signed(whole[DEG_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
        r_roll <= n_roll;
    end

    assign o_strobe       = r_strobe;
    assign o_roll_degrees = r_roll;

endmodule
`default_nettype wire

FILE: rtl/accel_tilt_angle.sv
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------
// sample in | input     | start, busy          | i_y_word, i_z_word (s16 each)
// roll out  | output    | o_strobe (one cycle) | o_roll_degrees (s9, -180..180)
//
// one transfer in per clock, busy is always low; the pipeline takes a sample
// pair every cycle with no gaps
// each result passes one input register, one register per cordic iteration
// and one output register
// i_rst_n is synchronous and clears only the valid bits; payload is not reset
// the receiver cannot stall, so results leave in order exactly one cycle each
`default_nettype none
module accel_tilt_angle (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [atilt_pkg::WORD_W-1:0] i_y_word,
    input  wire logic signed [atilt_pkg::WORD_W-1:0] i_z_word,
    output logic                                     o_strobe,
    output logic signed [atilt_pkg::DEG_W-1:0]       o_roll_degrees
);
    import atilt_pkg::*;

    logic   accept;
    logic   prep_valid, cordic_valid;
    t_stage prep_stage, cordic_stage;

    // fully pipelined, nothing ever holds the input off
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // scale by a quarter, catch axis and diagonal cases, fold the left half
    atilt_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_y_word (i_y_word),
        .i_z_word (i_z_word),
        .o_valid  (prep_valid),
        .o_stage  (prep_stage)
    );

    // vectoring cordic, one iteration per register stage
    atilt_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (prep_valid),
        .i_stage  (prep_stage),
        .o_valid  (cordic_valid),
        .o_stage  (cordic_stage)
    );

    // whole degrees, saturation and the special-case override
    atilt_post u_post (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (cordic_valid),
        .i_stage        (cordic_stage),
        .o_strobe       (o_strobe),
        .o_roll_degrees (o_roll_degrees)
    );

endmodule
`default_nettype wire

FILE: rtl/atilt_checker.sv
`default_nettype none
module atilt_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    input  wire logic                                busy,
    input  wire logic signed [atilt_pkg::WORD_W-1:0] i_y_word,
    input  wire logic signed [atilt_pkg::WORD_W-1:0] i_z_word,
    input  wire logic                                o_strobe,
    input  wire logic signed [atilt_pkg::DEG_W-1:0]  o_roll_degrees
);
    import atilt_pkg::*;

    localparam int WARM_W = $clog2(LATENCY + 1);

    logic [WARM_W-1:0] r_warm;
    logic              warm;

    // cycles since reset, up to the pipeline depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != WARM_W'(LATENCY)) begin
            r_warm <= r_warm + 1'b1;
        end
    end

    assign warm = (r_warm == WARM_W'(LATENCY));

    // one result strobe for each accepted transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        warm |-> (o_strobe == $past(start && !busy, LATENCY)))
        else $error("result strobe does not match transfer latency");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_roll_degrees >= -9'sd180 && o_roll_degrees <= 9'sd180))
        else $error("roll angle out of range");

    // y scales to zero with positive z: level
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && $past(start && !busy && i_y_word > -16'sd4 && i_y_word < 16'sd4
                       && i_z_word > 16'sd3, LATENCY))
        |-> (o_roll_degrees == 9'sd0))
        else $error("level sample gave nonzero roll");

    // z scales to zero with positive y: quarter turn
    a_upright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (warm && $past(start && !busy && i_z_word > -16'sd4 && i_z_word < 16'sd4
                       && i_y_word > 16'sd3, LATENCY))
        |-> (o_roll_degrees == 9'sd90))
        else $error("upright sample did not give 90 degrees");

endmodule

bind accel_tilt_angle atilt_checker u_atilt_checker (.*);
`default_nettype wire
